### design/i2cseq_pkg.sv
// shared types, codes and defaults for the i2c eeprom transaction sequencer
// no dependencies
package i2cseq_pkg;

    localparam int PAGE_BYTES_DEF = 64;
    localparam int PAGE_COUNT_DEF = 512;

    localparam int BUF_DEPTH = 64;
    localparam int BUF_AW    = 6;
    localparam int ADDR_W    = 15;
    localparam int RUN_W     = 7;

    localparam logic [6:0] DEV_ADDR_RESET = 7'h50;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_REQ   = 2'd1;
    localparam logic [1:0] FUNC_EVENT = 2'd2;

    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_TX      = 3'd2;
    localparam logic [2:0] CMD_RESTART = 3'd3;
    localparam logic [2:0] CMD_RX      = 3'd4;
    localparam logic [2:0] CMD_ACK     = 3'd5;
    localparam logic [2:0] CMD_NACK    = 3'd6;
    localparam logic [2:0] CMD_STOP    = 3'd7;

    localparam logic [1:0] STAT_NONE   = 2'd0;
    localparam logic [1:0] STAT_OK     = 2'd1;
    localparam logic [1:0] STAT_REJECT = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic       read_mode;
        logic [8:0] page_number;
        logic [5:0] page_offset;
        logic [6:0] byte_count;
        logic [5:0] buffer_slot;
        logic [7:0] buffer_byte;
        logic       nack_seen;
        logic [7:0] received_byte;
    } item_t;

    typedef struct packed {
        logic [2:0] bus_command;
        logic [7:0] transmit_byte;
        logic       read_valid;
        logic [5:0] read_position;
        logic [7:0] read_byte;
        logic [1:0] request_status;
        logic       busy_flag;
        logic       error_flag;
    } result_t;

endpackage

### design/i2cseq_wbuf.sv
// 64-byte write buffer memory, one write and one registered read per cycle
// read forwards a same-cycle write; uses i2cseq_pkg
module i2cseq_wbuf (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [i2cseq_pkg::BUF_AW-1:0] wr_addr,
    input  logic [7:0]                    wr_data,
    input  logic [i2cseq_pkg::BUF_AW-1:0] rd_addr,
    output logic [7:0]                    rd_data
);

    logic [7:0] mem [i2cseq_pkg::BUF_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/i2cseq_fsm.sv
// transaction state and the per-beat next-state and result logic
// uses i2cseq_pkg; buffer data comes from i2cseq_wbuf
module i2cseq_fsm #(
    parameter int PAGE_BYTES = i2cseq_pkg::PAGE_BYTES_DEF,
    parameter int PAGE_COUNT = i2cseq_pkg::PAGE_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [6:0]                    cfg_wr_data,
    input  logic                          go,
    input  i2cseq_pkg::item_t             item,
    input  logic [7:0]                    buf_data,
    output logic [i2cseq_pkg::BUF_AW-1:0] buf_raddr,
    output i2cseq_pkg::result_t           res
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_DEVW    = 4'd1;
    localparam logic [3:0] PH_ADRH    = 4'd2;
    localparam logic [3:0] PH_ADRL    = 4'd3;
    localparam logic [3:0] PH_WDATA   = 4'd4;
    localparam logic [3:0] PH_RESTART = 4'd5;
    localparam logic [3:0] PH_DEVR    = 4'd6;
    localparam logic [3:0] PH_RDATA   = 4'd7;
    localparam logic [3:0] PH_ACKED   = 4'd8;
    localparam logic [3:0] PH_NACKED  = 4'd9;
    localparam logic [3:0] PH_STOP    = 4'd10;

    localparam int PB_W   = $clog2(PAGE_BYTES + 1);
    localparam int PROD_W = 9 + PB_W + 1;
    localparam int PC_W   = $clog2(PAGE_COUNT + 1) + 1;
    localparam int SPAN_W = (PB_W > 8 ? PB_W : 8) + 1;

    logic [6:0]                      dev_reg;
    logic [3:0]                      phase_reg, phase_next;
    logic [i2cseq_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic                            dir_reg, dir_next;
    logic [i2cseq_pkg::RUN_W-1:0]    len_reg, len_next;
    logic [i2cseq_pkg::RUN_W-1:0]    idx_reg, idx_next;
    logic                            busy_reg, busy_next;
    logic                            err_reg, err_next;

    logic [PROD_W-1:0]               start_addr;
    logic [SPAN_W-1:0]               span;
    logic                            req_ok;
    logic [i2cseq_pkg::RUN_W-1:0]    idx_inc;

    assign start_addr = PROD_W'(item.page_number) * PROD_W'(PAGE_BYTES)
                      + PROD_W'(item.page_offset);
    assign span       = SPAN_W'(item.page_offset) + SPAN_W'(item.byte_count);
    assign req_ok     = !busy_reg && (item.byte_count != 7'd0)
                      && (PC_W'(item.page_number) < PC_W'(PAGE_COUNT))
                      && (span <= SPAN_W'(PAGE_BYTES));
    assign idx_inc    = idx_reg + 7'd1;

    always_comb
    begin
        phase_next = phase_reg;
        addr_next  = addr_reg;
        dir_next   = dir_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        err_next   = err_reg;
        res        = '0;
        if (go)
        begin
            unique case (item.func)
                i2cseq_pkg::FUNC_LOAD:
                begin
                end
                i2cseq_pkg::FUNC_REQ:
                begin
                    if (req_ok)
                    begin
                        res.request_status = i2cseq_pkg::STAT_OK;
                        addr_next  = start_addr[i2cseq_pkg::ADDR_W-1:0];
                        dir_next   = item.read_mode;
                        len_next   = item.byte_count;
                        idx_next   = '0;
                        busy_next  = 1'b1;
                        phase_next = PH_IDLE;
                        res.bus_command = i2cseq_pkg::CMD_START;
                    end
                    else
                    begin
                        res.request_status = i2cseq_pkg::STAT_REJECT;
                    end
                end
                i2cseq_pkg::FUNC_EVENT:
                begin
                    if (busy_reg)
                    begin
                        unique case (phase_reg)
                            PH_IDLE:
                            begin
                                res.bus_command   = i2cseq_pkg::CMD_TX;
                                res.transmit_byte = {dev_reg, 1'b0};
                                phase_next        = PH_DEVW;
                            end
                            PH_DEVW, PH_ADRH, PH_ADRL, PH_WDATA, PH_DEVR:
                            begin
                                if (item.nack_seen)
                                begin
                                    err_next        = 1'b1;
                                    res.bus_command = i2cseq_pkg::CMD_STOP;
                                    phase_next      = PH_STOP;
                                end
                                else if (phase_reg == PH_DEVW)
                                begin
                                    err_next          = 1'b0;
                                    res.bus_command   = i2cseq_pkg::CMD_TX;
                                    res.transmit_byte = {1'b0, addr_reg[14:8]};
                                    phase_next        = PH_ADRH;
                                end
                                else if (phase_reg == PH_ADRH)
                                begin
                                    res.bus_command   = i2cseq_pkg::CMD_TX;
                                    res.transmit_byte = addr_reg[7:0];
                                    phase_next        = PH_ADRL;
                                end
                                else if (phase_reg == PH_DEVR)
                                begin
                                    res.bus_command = i2cseq_pkg::CMD_RX;
                                    phase_next      = PH_RDATA;
                                end
                                else if (phase_reg == PH_ADRL && dir_reg)
                                begin
                                    res.bus_command = i2cseq_pkg::CMD_RESTART;
                                    phase_next      = PH_RESTART;
                                end
                                else if (phase_reg == PH_ADRL || idx_reg < len_reg)
                                begin
                                    res.bus_command   = i2cseq_pkg::CMD_TX;
                                    res.transmit_byte = buf_data;
                                    idx_next          = idx_inc;
                                    phase_next        = PH_WDATA;
                                end
                                else
                                begin
                                    res.bus_command = i2cseq_pkg::CMD_STOP;
                                    phase_next      = PH_STOP;
                                end
                            end
                            PH_RESTART:
                            begin
                                res.bus_command   = i2cseq_pkg::CMD_TX;
                                res.transmit_byte = {dev_reg, 1'b1};
                                phase_next        = PH_DEVR;
                            end
                            PH_RDATA:
                            begin
                                res.read_valid    = 1'b1;
                                res.read_position = idx_reg[5:0];
                                res.read_byte     = item.received_byte;
                                idx_next          = idx_inc;
                                if (idx_inc < len_reg)
                                begin
                                    res.bus_command = i2cseq_pkg::CMD_ACK;
                                    phase_next      = PH_ACKED;
                                end
                                else
                                begin
                                    res.bus_command = i2cseq_pkg::CMD_NACK;
                                    phase_next      = PH_NACKED;
                                end
                            end
                            PH_ACKED:
                            begin
                                res.bus_command = i2cseq_pkg::CMD_RX;
                                phase_next      = PH_RDATA;
                            end
                            PH_NACKED:
                            begin
                                res.bus_command = i2cseq_pkg::CMD_STOP;
                                phase_next      = PH_STOP;
                            end
                            PH_STOP:
                            begin
                                phase_next = PH_IDLE;
                                busy_next  = 1'b0;
                            end
                            default:
                            begin
                                err_next   = 1'b1;
                                busy_next  = 1'b0;
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
        res.busy_flag  = busy_next;
        res.error_flag = err_next;
    end

    // prefetch the slot that the next beat may send
    assign buf_raddr = idx_next[i2cseq_pkg::BUF_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_reg   <= i2cseq_pkg::DEV_ADDR_RESET;
            phase_reg <= PH_IDLE;
            addr_reg  <= '0;
            dir_reg   <= 1'b0;
            len_reg   <= '0;
            idx_reg   <= '0;
            busy_reg  <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                dev_reg <= cfg_wr_data;
            end
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            dir_reg   <= dir_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            busy_reg  <= busy_next;
            err_reg   <= err_next;
        end
    end

endmodule

### design/i2c_eeprom_transaction_sequencer.sv
// Page-bounded EEPROM read/write sequencer for an I2C master. Every beat on the
// input channel yields exactly one result beat, and a new beat is taken every
// cycle while the output is not stalled: an input register feeds one pass of
// next-state logic that writes the result register. The 64-byte write buffer
// is a memory with a registered read port that prefetches the slot the next
// transmit will need, forwarding a load to the same slot.
// depends on i2cseq_pkg, i2cseq_wbuf and i2cseq_fsm
module i2c_eeprom_transaction_sequencer #(
    parameter int PAGE_BYTES = i2cseq_pkg::PAGE_BYTES_DEF,
    parameter int PAGE_COUNT = i2cseq_pkg::PAGE_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    input  logic       read_mode,
    input  logic [8:0] page_number,
    input  logic [5:0] page_offset,
    input  logic [6:0] byte_count,
    input  logic [5:0] buffer_slot,
    input  logic [7:0] buffer_byte,
    input  logic       nack_seen,
    input  logic [7:0] received_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] bus_command,
    output logic [7:0] transmit_byte,
    output logic       read_valid,
    output logic [5:0] read_position,
    output logic [7:0] read_byte,
    output logic [1:0] request_status,
    output logic       busy_flag,
    output logic       error_flag
);

    i2cseq_pkg::item_t               item_reg;
    logic                            in_full_reg;
    i2cseq_pkg::result_t             res_reg;
    i2cseq_pkg::result_t             res;
    logic                            out_full_reg;
    logic                            adv;
    logic                            accept;
    logic [7:0]                      buf_data;
    logic [i2cseq_pkg::BUF_AW-1:0]   buf_raddr;

    assign adv      = in_full_reg && (!out_full_reg || !out_stall);
    assign in_stall = in_full_reg && !adv;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_full_reg <= 1'b1;
            end
            else if (adv)
            begin
                in_full_reg <= 1'b0;
            end
            if (adv)
            begin
                out_full_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.func          <= func;
            item_reg.read_mode     <= read_mode;
            item_reg.page_number   <= page_number;
            item_reg.page_offset   <= page_offset;
            item_reg.byte_count    <= byte_count;
            item_reg.buffer_slot   <= buffer_slot;
            item_reg.buffer_byte   <= buffer_byte;
            item_reg.nack_seen     <= nack_seen;
            item_reg.received_byte <= received_byte;
        end
        if (adv)
        begin
            res_reg <= res;
        end
    end

    i2cseq_wbuf u_wbuf (
        .clk     (clk),
        .wr_en   (adv && (item_reg.func == i2cseq_pkg::FUNC_LOAD)),
        .wr_addr (item_reg.buffer_slot),
        .wr_data (item_reg.buffer_byte),
        .rd_addr (buf_raddr),
        .rd_data (buf_data)
    );

    i2cseq_fsm #(
        .PAGE_BYTES (PAGE_BYTES),
        .PAGE_COUNT (PAGE_COUNT)
    ) u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .go          (adv),
        .item        (item_reg),
        .buf_data    (buf_data),
        .buf_raddr   (buf_raddr),
        .res         (res)
    );

    assign out_valid      = out_full_reg;
    assign bus_command    = res_reg.bus_command;
    assign transmit_byte  = res_reg.transmit_byte;
    assign read_valid     = res_reg.read_valid;
    assign read_position  = res_reg.read_position;
    assign read_byte      = res_reg.read_byte;
    assign request_status = res_reg.request_status;
    assign busy_flag      = res_reg.busy_flag;
    assign error_flag     = res_reg.error_flag;

endmodule

### design/i2cseq_checker.sv
// port-level checks on the sequencer result channel, bound to the top level
// uses i2cseq_pkg and i2c_eeprom_transaction_sequencer
module i2cseq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] bus_command,
    input logic [7:0] transmit_byte,
    input logic       read_valid,
    input logic [1:0] request_status,
    input logic       busy_flag
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bus_command)
            && $stable(transmit_byte) && $stable(request_status))
        else $error("stalled result beat changed");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (request_status == i2cseq_pkg::STAT_OK)
            |-> busy_flag && (bus_command == i2cseq_pkg::CMD_START))
        else $error("accepted request without start or busy");

    a_read_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_valid |-> (bus_command == i2cseq_pkg::CMD_ACK)
            || (bus_command == i2cseq_pkg::CMD_NACK))
        else $error("read byte without ack or nack");

    a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (bus_command != i2cseq_pkg::CMD_TX) |-> transmit_byte == 8'd0)
        else $error("transmit byte set without transmit command");

endmodule

bind i2c_eeprom_transaction_sequencer i2cseq_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .bus_command    (bus_command),
    .transmit_byte  (transmit_byte),
    .read_valid     (read_valid),
    .request_status (request_status),
    .busy_flag      (busy_flag)
);

### bench/tb_i2c_eeprom_transaction_sequencer.sv
`timescale 1ns / 1ps
// self-checking bench for i2c_eeprom_transaction_sequencer: directed table, then random
// page requests, buffer loads and bus events, checked against a local sequencer predictor
// depends on i2cseq_pkg and the design files
module tb_i2c_eeprom_transaction_sequencer;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int RANDOM_PHASES = 5;
    localparam int PRESSURE_PHASE = 4;
    localparam int HOLD_CYCLES = 60;
    localparam int SETTLE_CYCLES = 6;
    localparam int LIMIT_CYCLES = 200000;

    typedef enum logic [3:0] {
        PH_IDLE, PH_DEVW, PH_ADRH, PH_ADRL, PH_WDATA, PH_RESTART,
        PH_DEVR, PH_RDATA, PH_ACKED, PH_NACKED, PH_STOP
    } seq_phase_t;

    typedef struct {
        i2cseq_pkg::item_t   beat;
        bit                  typed;
        i2cseq_pkg::result_t want;
    } directed_row_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [6:0] cfg_wr_data = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] func = '0;
    logic       read_mode = 1'b0;
    logic [8:0] page_number = '0;
    logic [5:0] page_offset = '0;
    logic [6:0] byte_count = '0;
    logic [5:0] buffer_slot = '0;
    logic [7:0] buffer_byte = '0;
    logic       nack_seen = 1'b0;
    logic [7:0] received_byte = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] bus_command;
    logic [7:0] transmit_byte;
    logic       read_valid;
    logic [5:0] read_position;
    logic [7:0] read_byte;
    logic [1:0] request_status;
    logic       busy_flag;
    logic       error_flag;

    // predictor state
    seq_phase_t  seq_phase = PH_IDLE;
    logic [14:0] mem_addr = '0;
    logic        dir_read = 1'b0;
    logic [6:0]  run_len = '0;
    logic [7:0]  run_idx = '0;
    logic [7:0]  wbuf [i2cseq_pkg::BUF_DEPTH];
    logic [63:0] slot_loaded = '0;
    logic        busy_bit = 1'b0;
    logic        nack_err = 1'b0;
    logic [6:0]  dev_addr = i2cseq_pkg::DEV_ADDR_RESET;

    i2cseq_pkg::result_t expected_bus_results [$];
    directed_row_t       directed_rows [$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;
    int idle_plan [RANDOM_PHASES] = '{0, 58, 0, 37, 0};
    int stall_plan [RANDOM_PHASES] = '{0, 0, 58, 37, 0};

    i2c_eeprom_transaction_sequencer dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .read_mode(read_mode),
        .page_number(page_number),
        .page_offset(page_offset),
        .byte_count(byte_count),
        .buffer_slot(buffer_slot),
        .buffer_byte(buffer_byte),
        .nack_seen(nack_seen),
        .received_byte(received_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .bus_command(bus_command),
        .transmit_byte(transmit_byte),
        .read_valid(read_valid),
        .read_position(read_position),
        .read_byte(read_byte),
        .request_status(request_status),
        .busy_flag(busy_flag),
        .error_flag(error_flag)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic bit request_fits(i2cseq_pkg::item_t it);
        return !busy_bit && it.byte_count != 0
            && int'(it.page_number) < i2cseq_pkg::PAGE_COUNT_DEF
            && int'(it.page_offset) + int'(it.byte_count) <= i2cseq_pkg::PAGE_BYTES_DEF;
    endfunction

    function automatic i2cseq_pkg::result_t predict_bus_step(i2cseq_pkg::item_t it);
        i2cseq_pkg::result_t r;
        r = '0;
        unique case (it.func)
            i2cseq_pkg::FUNC_LOAD:
            begin
                wbuf[it.buffer_slot] = it.buffer_byte;
                slot_loaded[it.buffer_slot] = 1'b1;
            end
            i2cseq_pkg::FUNC_REQ:
            begin
                if (request_fits(it))
                begin
                    r.request_status = i2cseq_pkg::STAT_OK;
                    r.bus_command = i2cseq_pkg::CMD_START;
                    mem_addr = 15'(int'(it.page_number) * i2cseq_pkg::PAGE_BYTES_DEF
                        + int'(it.page_offset));
                    dir_read = it.read_mode;
                    run_len = it.byte_count;
                    run_idx = '0;
                    busy_bit = 1'b1;
                    seq_phase = PH_IDLE;
                end
                else
                    r.request_status = i2cseq_pkg::STAT_REJECT;
            end
            i2cseq_pkg::FUNC_EVENT:
            begin
                if (!busy_bit)
                    ;
                else if (seq_phase inside {PH_DEVW, PH_ADRH, PH_ADRL, PH_WDATA, PH_DEVR}
                    && it.nack_seen)
                begin
                    nack_err = 1'b1;
                    r.bus_command = i2cseq_pkg::CMD_STOP;
                    seq_phase = PH_STOP;
                end
                else
                begin
                    unique case (seq_phase)
                        PH_IDLE:
                        begin
                            r.bus_command = i2cseq_pkg::CMD_TX;
                            r.transmit_byte = {dev_addr, 1'b0};
                            seq_phase = PH_DEVW;
                        end
                        PH_DEVW:
                        begin
                            nack_err = 1'b0;
                            r.bus_command = i2cseq_pkg::CMD_TX;
                            r.transmit_byte = {1'b0, mem_addr[14:8]};
                            seq_phase = PH_ADRH;
                        end
                        PH_ADRH:
                        begin
                            r.bus_command = i2cseq_pkg::CMD_TX;
                            r.transmit_byte = mem_addr[7:0];
                            seq_phase = PH_ADRL;
                        end
                        PH_ADRL, PH_WDATA:
                        begin
                            if (seq_phase == PH_ADRL && dir_read)
                            begin
                                r.bus_command = i2cseq_pkg::CMD_RESTART;
                                seq_phase = PH_RESTART;
                            end
                            else if (seq_phase == PH_WDATA && run_idx >= {1'b0, run_len})
                            begin
                                r.bus_command = i2cseq_pkg::CMD_STOP;
                                seq_phase = PH_STOP;
                            end
                            else
                            begin
                                r.bus_command = i2cseq_pkg::CMD_TX;
                                r.transmit_byte = wbuf[run_idx[5:0]];
                                run_idx = run_idx + 8'd1;
                                seq_phase = PH_WDATA;
                            end
                        end
                        PH_RESTART:
                        begin
                            r.bus_command = i2cseq_pkg::CMD_TX;
                            r.transmit_byte = {dev_addr, 1'b1};
                            seq_phase = PH_DEVR;
                        end
                        PH_DEVR, PH_ACKED:
                        begin
                            r.bus_command = i2cseq_pkg::CMD_RX;
                            seq_phase = PH_RDATA;
                        end
                        PH_RDATA:
                        begin
                            r.read_valid = 1'b1;
                            r.read_position = run_idx[5:0];
                            r.read_byte = it.received_byte;
                            run_idx = run_idx + 8'd1;
                            if (run_idx < {1'b0, run_len})
                            begin
                                r.bus_command = i2cseq_pkg::CMD_ACK;
                                seq_phase = PH_ACKED;
                            end
                            else
                            begin
                                r.bus_command = i2cseq_pkg::CMD_NACK;
                                seq_phase = PH_NACKED;
                            end
                        end
                        PH_NACKED:
                        begin
                            r.bus_command = i2cseq_pkg::CMD_STOP;
                            seq_phase = PH_STOP;
                        end
                        PH_STOP:
                        begin
                            busy_bit = 1'b0;
                            seq_phase = PH_IDLE;
                        end
                        default:
                        begin
                            nack_err = 1'b1;
                            busy_bit = 1'b0;
                            seq_phase = PH_IDLE;
                        end
                    endcase
                end
            end
            default: ;
        endcase
        r.busy_flag = busy_bit;
        r.error_flag = nack_err;
        return r;
    endfunction

    // mostly well-formed runs; noise in unused fields, some bad requests and stray beats
    function automatic i2cseq_pkg::item_t next_random_item();
        i2cseq_pkg::item_t it;
        logic [63:0] raw;
        int pick;
        int room;
        int k;
        raw = {$urandom, $urandom};
        it = raw[47:0];
        pick = $urandom_range(99);
        if (busy_bit)
        begin
            if (pick < 78)
            begin
                it.func = i2cseq_pkg::FUNC_EVENT;
                it.nack_seen = ($urandom_range(99) < 6);
            end
            else if (pick < 88)
                it.func = i2cseq_pkg::FUNC_LOAD;
            else if (pick < 96)
                it.func = i2cseq_pkg::FUNC_REQ;
            else
                it.func = FUNC_UNUSED;
        end
        else
        begin
            if (pick < 45)
                it.func = i2cseq_pkg::FUNC_REQ;
            else if (pick < 85)
                it.func = i2cseq_pkg::FUNC_LOAD;
            else if (pick < 95)
                it.func = i2cseq_pkg::FUNC_EVENT;
            else
                it.func = FUNC_UNUSED;
        end
        if (it.func == i2cseq_pkg::FUNC_REQ && $urandom_range(99) < 85)
        begin
            room = i2cseq_pkg::PAGE_BYTES_DEF - int'(it.page_offset);
            if ($urandom_range(3) != 0)
                it.byte_count = 7'($urandom_range(room < 8 ? room : 8, 1));
            else
                it.byte_count = 7'($urandom_range(room, 1));
        end
        if (it.func == i2cseq_pkg::FUNC_LOAD && $urandom_range(1) == 1 && slot_loaded != '1)
        begin
            k = 0;
            while (slot_loaded[k])
                k++;
            it.buffer_slot = 6'(k);
        end
        // a write run may only send slots that hold data
        if (it.func == i2cseq_pkg::FUNC_REQ && !it.read_mode && request_fits(it))
        begin
            for (k = 0; k < int'(it.byte_count); k++)
                if (!slot_loaded[k])
                    it.read_mode = 1'b1;
        end
        return it;
    endfunction

    function automatic i2cseq_pkg::item_t mk_beat(logic [1:0] f, logic rm, logic [8:0] pg,
        logic [5:0] of, logic [6:0] cnt, logic [5:0] sl, logic [7:0] b, logic nk,
        logic [7:0] rx);
        i2cseq_pkg::item_t it;
        it.func = f;
        it.read_mode = rm;
        it.page_number = pg;
        it.page_offset = of;
        it.byte_count = cnt;
        it.buffer_slot = sl;
        it.buffer_byte = b;
        it.nack_seen = nk;
        it.received_byte = rx;
        return it;
    endfunction

    function automatic i2cseq_pkg::result_t mk_result(logic [2:0] cmd, logic [1:0] st,
        logic bsy, logic err);
        i2cseq_pkg::result_t r;
        r = '0;
        r.bus_command = cmd;
        r.request_status = st;
        r.busy_flag = bsy;
        r.error_flag = err;
        return r;
    endfunction

    task automatic add_row(i2cseq_pkg::item_t b, bit typed, i2cseq_pkg::result_t w);
        directed_row_t row;
        row.beat = b;
        row.typed = typed;
        row.want = w;
        directed_rows.push_back(row);
    endtask

    task automatic send_beat(i2cseq_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        func <= it.func;
        read_mode <= it.read_mode;
        page_number <= it.page_number;
        page_offset <= it.page_offset;
        byte_count <= it.byte_count;
        buffer_slot <= it.buffer_slot;
        buffer_byte <= it.buffer_byte;
        nack_seen <= it.nack_seen;
        received_byte <= it.received_byte;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_device_address(logic [6:0] value);
        while (expected_bus_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        dev_addr = value;
        @(negedge clk);
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // receiver side: random stalls plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_left == 0 && hold_served != hold_asked)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        i2cseq_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bus_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                mismatches++;
            end
            else
            begin
                want = expected_bus_results.pop_front();
                check_field("bus_command", 8'(want.bus_command), 8'(bus_command));
                check_field("transmit_byte", want.transmit_byte, transmit_byte);
                check_field("read_valid", 8'(want.read_valid), 8'(read_valid));
                check_field("read_position", 8'(want.read_position), 8'(read_position));
                check_field("read_byte", want.read_byte, read_byte);
                check_field("request_status", 8'(want.request_status),
                    8'(request_status));
                check_field("busy_flag", 8'(want.busy_flag), 8'(busy_flag));
                check_field("error_flag", 8'(want.error_flag), 8'(error_flag));
            end
        end
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("** i2c_eeprom_transaction_sequencer: FAILED **");
        $finish;
    end

    initial
    begin
        i2cseq_pkg::item_t it;
        i2cseq_pkg::result_t predicted;

        // idle event, unused kind, bad sizes, loads
        add_row(mk_beat(i2cseq_pkg::FUNC_EVENT, 1'b0, 9'd0, 6'd0, 7'd0,
            6'd0, 8'd0, 1'b0, 8'hFF), 1'b1,
            mk_result(i2cseq_pkg::CMD_NONE, i2cseq_pkg::STAT_NONE, 1'b0, 1'b0));
        add_row(mk_beat(FUNC_UNUSED, 1'b1, 9'h1FF, 6'h3F, 7'h7F,
            6'h3F, 8'hFF, 1'b1, 8'hFF), 1'b1,
            mk_result(i2cseq_pkg::CMD_NONE, i2cseq_pkg::STAT_NONE, 1'b0, 1'b0));
        add_row(mk_beat(i2cseq_pkg::FUNC_REQ, 1'b0, 9'd0, 6'd0, 7'd0,
            6'd0, 8'd0, 1'b0, 8'd0), 1'b1,
            mk_result(i2cseq_pkg::CMD_NONE, i2cseq_pkg::STAT_REJECT, 1'b0, 1'b0));
        add_row(mk_beat(i2cseq_pkg::FUNC_REQ, 1'b1, 9'd3, 6'd63, 7'd2,
            6'd0, 8'd0, 1'b0, 8'd0), 1'b1,
            mk_result(i2cseq_pkg::CMD_NONE, i2cseq_pkg::STAT_REJECT, 1'b0, 1'b0));
        add_row(mk_beat(i2cseq_pkg::FUNC_REQ, 1'b0, 9'd0, 6'd0, 7'h7F,
            6'd0, 8'd0, 1'b0, 8'd0), 1'b1,
            mk_result(i2cseq_pkg::CMD_NONE, i2cseq_pkg::STAT_REJECT, 1'b0, 1'b0));
        add_row(mk_beat(i2cseq_pkg::FUNC_LOAD, 1'b0, 9'd0, 6'd0, 7'd0,
            6'd0, 8'hFF, 1'b0, 8'd0), 1'b1,
            mk_result(i2cseq_pkg::CMD_NONE, i2cseq_pkg::STAT_NONE, 1'b0, 1'b0));
        add_row(mk_beat(i2cseq_pkg::FUNC_LOAD, 1'b0, 9'd0, 6'd0, 7'd0,
            6'd1, 8'h00, 1'b0, 8'd0), 1'b1,
            mk_result(i2cseq_pkg::CMD_NONE, i2cseq_pkg::STAT_NONE, 1'b0, 1'b0));
        add_row(mk_beat(i2cseq_pkg::FUNC_LOAD, 1'b0, 9'd0, 6'd0, 7'd0,
            6'd63, 8'hA5, 1'b0, 8'd0), 1'b1,
            mk_result(i2cseq_pkg::CMD_NONE, i2cseq_pkg::STAT_NONE, 1'b0, 1'b0));
        // write run ending on the last page boundary, top address bits set
        add_row(mk_beat(i2cseq_pkg::FUNC_REQ, 1'b0, 9'd511, 6'd62, 7'd2,
            6'd0, 8'd0, 1'b0, 8'd0), 1'b1,
            mk_result(i2cseq_pkg::CMD_START, i2cseq_pkg::STAT_OK, 1'b1, 1'b0));
        add_row(mk_beat(i2cseq_pkg::FUNC_EVENT, 1'b0, 9'd0, 6'd0, 7'd0,
            6'd0, 8'd0, 1'b0, 8'd0), 1'b0, '0);
        add_row(mk_beat(i2cseq_pkg::FUNC_REQ, 1'b1, 9'd0, 6'd0, 7'd1,
            6'd0, 8'd0, 1'b0, 8'd0), 1'b1,
            mk_result(i2cseq_pkg::CMD_NONE, i2cseq_pkg::STAT_REJECT, 1'b1, 1'b0));
        add_row(mk_beat(i2cseq_pkg::FUNC_EVENT, 1'b0, 9'd0, 6'd0, 7'd0,
            6'd0, 8'd0, 1'b0, 8'd0), 1'b0, '0);
        add_row(mk_beat(i2cseq_pkg::FUNC_EVENT, 1'b0, 9'd0, 6'd0, 7'd0,
            6'd0, 8'd0, 1'b0, 8'd0), 1'b0, '0);
        // reload of a slot not yet sent
        add_row(mk_beat(i2cseq_pkg::FUNC_LOAD, 1'b0, 9'd0, 6'd0, 7'd0,
            6'd1, 8'h3C, 1'b0, 8'd0), 1'b0, '0);
        add_row(mk_beat(i2cseq_pkg::FUNC_EVENT, 1'b0, 9'd0, 6'd0, 7'd0,
            6'd0, 8'd0, 1'b0, 8'd0), 1'b0, '0);
        add_row(mk_beat(i2cseq_pkg::FUNC_EVENT, 1'b0, 9'd0, 6'd0, 7'd0,
            6'd0, 8'd0, 1'b0, 8'd0), 1'b0, '0);
        add_row(mk_beat(i2cseq_pkg::FUNC_EVENT, 1'b0, 9'd0, 6'd0, 7'd0,
            6'd0, 8'd0, 1'b0, 8'd0), 1'b0, '0);
        add_row(mk_beat(i2cseq_pkg::FUNC_EVENT, 1'b0, 9'd0, 6'd0, 7'd0,
            6'd0, 8'd0, 1'b0, 8'd0), 1'b0, '0);
        // read run where the device does not answer its address
        add_row(mk_beat(i2cseq_pkg::FUNC_REQ, 1'b1, 9'd0, 6'd63, 7'd1,
            6'd0, 8'd0, 1'b0, 8'd0), 1'b0, '0);
        add_row(mk_beat(i2cseq_pkg::FUNC_EVENT, 1'b0, 9'd0, 6'd0, 7'd0,
            6'd0, 8'd0, 1'b0, 8'd0), 1'b0, '0);
        add_row(mk_beat(i2cseq_pkg::FUNC_EVENT, 1'b0, 9'd0, 6'd0, 7'd0,
            6'd0, 8'd0, 1'b1, 8'd0), 1'b0, '0);
        add_row(mk_beat(i2cseq_pkg::FUNC_EVENT, 1'b0, 9'd0, 6'd0, 7'd0,
            6'd0, 8'd0, 1'b0, 8'd0), 1'b0, '0);
        add_row(mk_beat(i2cseq_pkg::FUNC_EVENT, 1'b0, 9'd0, 6'd0, 7'd0,
            6'd0, 8'd0, 1'b1, 8'hFF), 1'b1,
            mk_result(i2cseq_pkg::CMD_NONE, i2cseq_pkg::STAT_NONE, 1'b0, 1'b1));

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[k])
        begin
            predicted = predict_bus_step(directed_rows[k].beat);
            expected_bus_results.push_back(directed_rows[k].typed ? directed_rows[k].want
                : predicted);
            send_beat(directed_rows[k].beat);
        end
        in_valid <= 1'b0;

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            unique case (p)
                0: set_device_address(7'd127);
                1: set_device_address(7'd0);
                2: set_device_address(i2cseq_pkg::DEV_ADDR_RESET);
                default: set_device_address(7'($urandom));
            endcase
            send_idle_pct = idle_plan[p];
            recv_stall_pct = stall_plan[p];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (p == PRESSURE_PHASE && (n == 20 || n == 70))
                    hold_asked++;
                it = next_random_item();
                expected_bus_results.push_back(predict_bus_step(it));
                send_beat(it);
            end
            in_valid <= 1'b0;
        end

        while (expected_bus_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("** i2c_eeprom_transaction_sequencer: PASSED **");
        else
            $display("** i2c_eeprom_transaction_sequencer: FAILED **");
        $finish;
    end

endmodule
